FILE: sv/nrms3_pkg.sv
// Shared constants, types and helpers for the 3x3 neighborhood RMS core.
package nrms3_pkg;

	localparam int PIXEL_BITS  = 16;
	localparam int MAX_COLS    = 64;
	localparam int MAX_ROWS    = 64;
	localparam int COL_W       = $clog2(MAX_COLS);
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int ADDR_W      = COL_W + ROW_W;
	localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
	localparam int DIM_W       = 7;
	localparam int CNT_W       = 4;
	localparam int NB_LAST     = 8;

	// sum of nine squares of 16-bit pixels
	localparam int SQ_W        = 2 * PIXEL_BITS;
	localparam int SUM_W       = SQ_W + 4;
	localparam int ROOT_W      = PIXEL_BITS;
	localparam int REM_W       = ROOT_W + 1;
	localparam int ARG_W       = REM_W + 2;
	localparam int DIV_STEPS   = SUM_W;
	localparam int ROOT_STEPS  = ROOT_W;
	localparam int STEP_W      = $clog2(DIV_STEPS);

	// configuration register indexes
	localparam logic CFG_MAP_WIDTH  = 1'b0;
	localparam logic CFG_MAP_HEIGHT = 1'b1;

	// input kinds
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// column offset plus one (0..2) of neighbor nb, scan order row-major
	function automatic logic [1:0] nb_dx(input logic [CNT_W-1:0] nb);
		logic [1:0] d;
		case (nb)
			4'd0, 4'd3, 4'd6: d = 2'd0;
			4'd1, 4'd4, 4'd7: d = 2'd1;
			default:          d = 2'd2;
		endcase
		return d;
	endfunction

	// row offset plus one (0..2) of neighbor nb
	function automatic logic [1:0] nb_dy(input logic [CNT_W-1:0] nb);
		logic [1:0] d;
		case (nb)
			4'd0, 4'd1, 4'd2: d = 2'd0;
			4'd3, 4'd4, 4'd5: d = 2'd1;
			default:          d = 2'd2;
		endcase
		return d;
	endfunction

endpackage

FILE: sv/nrms3_divsqrt.sv
// Iterative mean and root unit: long division by the count, then a bit-pair square root.
module nrms3_divsqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [nrms3_pkg::SUM_W-1:0] dividend,
	input  logic [nrms3_pkg::CNT_W-1:0] divisor,
	output logic                        done,
	output logic [nrms3_pkg::ROOT_W-1:0] root
);
	import nrms3_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_DIV  = 3'b010,
		PH_SQRT = 3'b100
	} phase_t;

	phase_t             phase_q;
	logic [STEP_W-1:0]  step_q;
	logic [SUM_W-1:0]   dq_q;    // dividend shifting out, quotient shifting in
	logic [CNT_W-1:0]   div_q;
	logic [CNT_W-1:0]   r_q;     // division remainder, always below divisor
	logic [REM_W-1:0]   rem_q;   // root remainder
	logic [ROOT_W-1:0]  root_q;
	logic               done_q;

	// the one subtractor both phases share
	logic [ARG_W-1:0]   op_a;
	logic [ARG_W-1:0]   op_b;
	logic [ARG_W:0]     diff;
	logic               ge;

	always_comb begin
		if (phase_q == PH_DIV) begin
			op_a = {{(ARG_W-CNT_W-1){1'b0}}, r_q, dq_q[SUM_W-1]};
			op_b = {{(ARG_W-CNT_W){1'b0}}, div_q};
		end else begin
			op_a = {rem_q, dq_q[SQ_W-1 -: 2]};
			op_b = {1'b0, root_q, 2'b01};
		end
		diff = {1'b0, op_a} - {1'b0, op_b};
		ge   = ~diff[ARG_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			step_q  <= '0;
			dq_q    <= '0;
			div_q   <= '0;
			r_q     <= '0;
			rem_q   <= '0;
			root_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (phase_q == PH_SQRT) && (step_q == '0);
			unique case (phase_q)
				PH_IDLE: begin
					if (start) begin
						dq_q    <= dividend;
						div_q   <= divisor;
						r_q     <= '0;
						step_q  <= STEP_W'(DIV_STEPS - 1);
						phase_q <= PH_DIV;
					end
				end
				PH_DIV: begin
					r_q  <= ge ? diff[CNT_W-1:0] : op_a[CNT_W-1:0];
					dq_q <= {dq_q[SUM_W-2:0], ge};
					if (step_q == '0) begin
						step_q  <= STEP_W'(ROOT_STEPS - 1);
						rem_q   <= '0;
						root_q  <= '0;
						phase_q <= PH_SQRT;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				PH_SQRT: begin
					rem_q  <= ge ? diff[REM_W-1:0] : op_a[REM_W-1:0];
					root_q <= {root_q[ROOT_W-2:0], ge};
					dq_q   <= {dq_q[SUM_W-3:0], 2'b00};
					if (step_q == '0) begin
						phase_q <= PH_IDLE;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: sv/neighborhood_rms_3x3_core.sv
// Top level of the 3x3 neighborhood RMS core: pixel store, neighbor scan and result register.
//
// Usage:
//  - Input stream (s_*): s_tuser 0 writes the pixel of s_tdata (col, row, pixel_value) if it
//    lies inside the configured map, 1 queries; only a query produces an output item.
//  - Output stream (m_*): m_tdata carries rms_value and neighbor_count,
//    m_tuser is the empty flag (no neighbor inside the map, rms 0, count 0).
//  - cfg_we/cfg_index/cfg_data write map_width (index 0) and map_height
//    (index 1). Write them only while the core is idle.
//  - Sequence: a query scans its nine neighbors on the single store port, drains the read
//    and square stages, then runs division and root on one shared subtractor before the
//    handoff; s_tready returns with output valid, so a query holds the input until its
//    result is registered. An empty query skips the arithmetic.
//  - The result sits in an output register, so the next item is taken while a
//    result waits; a query finishing before the receiver takes the earlier result
//    holds in its last state until m_tready frees the register.
//  - Reset sets both dimensions to 64 and empties the pipeline; store contents
//    are undefined until written.
module neighborhood_rms_3x3_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [nrms3_pkg::DIM_W-1:0] cfg_data,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [31:0]                 s_tdata,   // col[5:0], row[11:6], pixel_value[27:12]
	input  logic                        s_tuser,   // action
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [23:0]                 m_tdata,   // rms_value[15:0], neighbor_count[19:16]
	output logic                        m_tuser    // empty_flag
);
	import nrms3_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_CALC  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t              state_q;
	logic [DIM_W-1:0]    width_q;
	logic [DIM_W-1:0]    height_q;
	logic [DIM_W-1:0]    w_eff;
	logic [DIM_W-1:0]    h_eff;

	// input fields
	logic [COL_W-1:0]      in_col;
	logic [ROW_W-1:0]      in_row;
	logic [PIXEL_BITS-1:0] in_pix;
	logic                  in_fire;
	logic                  wr_en;

	// query state
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic [CNT_W-1:0]    nb_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SUM_W-1:0]    acc_q;

	// neighbor address generation
	logic [DIM_W-1:0]    xp;
	logic [DIM_W-1:0]    yp;
	logic [DIM_W-1:0]    xm;
	logic [DIM_W-1:0]    ym;
	logic                nb_in;
	logic                rd_en;
	logic [ADDR_W-1:0]   rd_addr;

	// read and square stages
	logic                  live_s1;
	logic                  vld_s1;
	logic [PIXEL_BITS-1:0] dat_s1;
	logic                  live_s2;
	logic                  vld_s2;
	logic [SQ_W-1:0]       sq_s2;

	logic [PIXEL_BITS-1:0] mem [STORE_DEPTH];

	// mean/root unit
	logic                ms_start;
	logic                ms_done;
	logic [ROOT_W-1:0]   ms_root;

	// output register
	logic                m_tvalid_q;
	logic [ROOT_W-1:0]   rms_q;
	logic [CNT_W-1:0]    cnt_out_q;
	logic                empty_q;
	logic                out_free;

	assign in_col = s_tdata[COL_W-1:0];
	assign in_row = s_tdata[COL_W +: ROW_W];
	assign in_pix = s_tdata[COL_W+ROW_W +: PIXEL_BITS];

	// oversized dimensions clamp to the store size
	assign w_eff = (width_q  > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : width_q;
	assign h_eff = (height_q > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : height_q;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign wr_en    = in_fire && (s_tuser == ACT_WRITE)
	                  && ({1'b0, in_col} < w_eff) && ({1'b0, in_row} < h_eff);

	// neighbor coordinates carry a +1 bias so the left/top edge stays unsigned
	assign xp = {1'b0, col_q} + {{(DIM_W-2){1'b0}}, nb_dx(nb_q)};
	assign yp = {1'b0, row_q} + {{(DIM_W-2){1'b0}}, nb_dy(nb_q)};
	assign xm = xp - 1'b1;
	assign ym = yp - 1'b1;
	assign nb_in = (xp != '0) && (yp != '0) && (xm < w_eff) && (ym < h_eff);
	assign rd_en   = (state_q == ST_SCAN) && nb_in;
	assign rd_addr = {ym[ROW_W-1:0], xm[COL_W-1:0]};

	assign out_free = !m_tvalid_q || m_tready;
	assign ms_start = (state_q == ST_DRAIN) && !live_s1 && !live_s2 && (cnt_q != '0);

	// pixel store and datapath payload
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[{in_row, in_col}] <= in_pix;
		end
		if (rd_en) begin
			dat_s1 <= mem[rd_addr];
		end
		sq_s2 <= {{(SQ_W-PIXEL_BITS){1'b0}}, dat_s1} * {{(SQ_W-PIXEL_BITS){1'b0}}, dat_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			width_q    <= DIM_W'(MAX_COLS);
			height_q   <= DIM_W'(MAX_ROWS);
			col_q      <= '0;
			row_q      <= '0;
			nb_q       <= '0;
			cnt_q      <= '0;
			acc_q      <= '0;
			live_s1    <= 1'b0;
			vld_s1     <= 1'b0;
			live_s2    <= 1'b0;
			vld_s2     <= 1'b0;
			m_tvalid_q <= 1'b0;
			rms_q      <= '0;
			cnt_out_q  <= '0;
			empty_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MAP_WIDTH:  width_q  <= cfg_data;
					CFG_MAP_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end

			live_s1 <= (state_q == ST_SCAN);
			vld_s1  <= rd_en;
			live_s2 <= live_s1;
			vld_s2  <= vld_s1;
			if (vld_s2) begin
				acc_q <= acc_q + {{(SUM_W-SQ_W){1'b0}}, sq_s2};
			end

			// output valid: set when a result lands, cleared when it is taken
			if ((state_q == ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && (s_tuser == ACT_QUERY)) begin
						col_q   <= in_col;
						row_q   <= in_row;
						nb_q    <= '0;
						cnt_q   <= '0;
						acc_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (nb_in) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (nb_q == CNT_W'(NB_LAST)) begin
						state_q <= ST_DRAIN;
					end else begin
						nb_q <= nb_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!live_s1 && !live_s2) begin
						state_q <= (cnt_q == '0) ? ST_DONE : ST_CALC;
					end
				end
				ST_CALC: begin
					if (ms_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						rms_q      <= (cnt_q == '0) ? '0 : ms_root;
						cnt_out_q  <= cnt_q;
						empty_q    <= (cnt_q == '0);
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	nrms3_divsqrt u_divsqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ms_start),
		.dividend (acc_q),
		.divisor  (cnt_q),
		.done     (ms_done),
		.root     (ms_root)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(24-ROOT_W-CNT_W){1'b0}}, cnt_out_q, rms_q};
	assign m_tuser  = empty_q;

endmodule

FILE: tb/sv/neighborhood_rms_3x3_core_tb.sv
// Testbench for the 3x3 neighborhood RMS core: random and directed pixel writes and queries.
//
// An initial block builds the items for each phase and places them in a queue. A clocked
// driver takes items from that queue and sends them on the input stream. When the core
// accepts an item, the driver passes it to an in-bench model of the pixel map. For each
// query, that model works out the expected rms, count and empty flag. A clocked receiver
// checks each result item against the oldest expected one, field by field.
//
// Between phases the map size is written only while the core is idle. The stimulus never
// reads a store entry that was never written. Before a query, the generator fills any
// in-map neighbor that is still unwritten.
module neighborhood_rms_3x3_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import nrms3_pkg::*;

	// Longest stretch with no item moving on either side in a correct run:
	// the receiver hold of HOLD_CYCLES, plus two queries behind it,
	// plus the drain of DRAIN_CYCLES. The limit is set several times over that.
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 100;
	localparam int QUIET_LIMIT  = 4000;
	localparam int IDLE_PCT     = 10;
	localparam int MAX_REPORTS  = 40;

	typedef struct {
		logic        action;
		logic [5:0]  col;
		logic [5:0]  row;
		logic [15:0] pixel;
	} pixel_op_t;

	typedef struct packed {
		logic [15:0] rms;
		logic [3:0]  count;
		logic        empty;
	} rms_result_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic                 cfg_index = CFG_MAP_WIDTH;
	logic [DIM_W-1:0]     cfg_data  = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [31:0]          s_tdata   = '0;   // col[5:0], row[11:6], pixel_value[27:12]
	logic                 s_tuser   = ACT_WRITE;   // action
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [23:0]          m_tdata;          // rms_value[15:0], neighbor_count[19:16]
	logic                 m_tuser;          // empty_flag

	neighborhood_rms_3x3_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// items waiting to be sent, and results waiting to arrive
	pixel_op_t   pixel_ops[$];
	rms_result_t rms_expected[$];

	// in-bench copy of the map: register values and store contents
	logic [DIM_W-1:0] model_width  = 7'd64;
	logic [DIM_W-1:0] model_height = 7'd64;
	logic [15:0]      model_pix[MAX_COLS*MAX_ROWS];

	// generator side: map size in force and which cells hold a value
	int  gen_w = MAX_COLS;
	int  gen_h = MAX_ROWS;
	bit  gen_written[MAX_COLS*MAX_ROWS];
	int  items_made;

	// knobs shared with driver and receiver
	bit  idle_en;
	bit  hold_go;
	bit  hold_seen;
	int  hold_left;

	int  err_count;
	int  n_writes, n_queries, n_empty, n_full, n_settings;

	function automatic int eff_dim(input logic [DIM_W-1:0] d, input int lim);
		return (int'(d) > lim) ? lim : int'(d);
	endfunction

	function automatic void report_mismatch(input string what, input longint got,
	                                        input longint want);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
	endfunction

	// Applies one accepted item to the map model; a query adds its expected result.
	function automatic void apply_pixel_op(input logic act, input logic [5:0] c,
	                                       input logic [5:0] r, input logic [15:0] v);
		int              ew, eh, x, y;
		int unsigned     cnt;
		longint unsigned sum_sq, mean, p, trial;
		logic [15:0]     root;
		ew = eff_dim(model_width, MAX_COLS);
		eh = eff_dim(model_height, MAX_ROWS);
		if (act == ACT_WRITE) begin
			n_writes++;
			// out-of-map writes leave the store alone
			if (int'(c) < ew && int'(r) < eh)
				model_pix[int'(r) * MAX_COLS + int'(c)] = v;
			return;
		end
		n_queries++;
		cnt    = 0;
		sum_sq = 0;
		for (int dy = -1; dy <= 1; dy++) begin
			for (int dx = -1; dx <= 1; dx++) begin
				x = int'(c) + dx;
				y = int'(r) + dy;
				if (x >= 0 && x < ew && y >= 0 && y < eh) begin
					p = model_pix[y * MAX_COLS + x];
					sum_sq += p * p;
					cnt++;
				end
			end
		end
		if (cnt == 0) begin
			rms_expected.push_back('{rms: 16'd0, count: 4'd0, empty: 1'b1});
			return;
		end
		// floored mean of exact squares, then floored root bit by bit
		mean = sum_sq / cnt;
		root = '0;
		for (int b = 15; b >= 0; b--) begin
			trial = longint'(root) | (64'd1 << b);
			if (trial * trial <= mean)
				root = trial[15:0];
		end
		rms_expected.push_back('{rms: root, count: cnt[3:0], empty: 1'b0});
	endfunction

	function automatic logic [15:0] rand_pixel();
		case ($urandom_range(9))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic void push_write(input int c, input int r, input logic [15:0] v);
		pixel_ops.push_back('{action: ACT_WRITE, col: c[5:0], row: r[5:0], pixel: v});
		items_made++;
		if (c < gen_w && r < gen_h)
			gen_written[r * MAX_COLS + c] = 1'b1;
	endfunction

	// Fills every in-map neighbor that still lacks a value, then sends the query.
	function automatic void push_query(input int c, input int r);
		int x, y;
		for (int dy = -1; dy <= 1; dy++) begin
			for (int dx = -1; dx <= 1; dx++) begin
				x = c + dx;
				y = r + dy;
				if (x >= 0 && x < gen_w && y >= 0 && y < gen_h &&
				    !gen_written[y * MAX_COLS + x])
					push_write(x, y, rand_pixel());
			end
		end
		pixel_ops.push_back('{action: ACT_QUERY, col: c[5:0], row: r[5:0], pixel: rand_pixel()});
		items_made++;
	endfunction

	// Coordinate near the live area: anywhere up to one past the edge, or hugging an edge.
	function automatic int near_coord(input int dim);
		int top, v;
		top = (dim > 63) ? 63 : dim;
		if (dim <= 8 || $urandom_range(1))
			return $urandom_range(top);
		if ($urandom_range(1))
			return $urandom_range(2);
		v = dim - 3 + int'($urandom_range(3));
		return (v > 63) ? 63 : v;
	endfunction

	// Waits until the core has nothing left in flight.
	task automatic wait_quiet();
		while (pixel_ops.size() != 0 || s_tvalid || rms_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_map(input int w, input int h);
		wait_quiet();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MAP_WIDTH;
		cfg_data  <= w[DIM_W-1:0];
		@(posedge clk);
		cfg_index <= CFG_MAP_HEIGHT;
		cfg_data  <= h[DIM_W-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		model_width  = w[DIM_W-1:0];
		model_height = h[DIM_W-1:0];
		gen_w = eff_dim(w[DIM_W-1:0], MAX_COLS);
		gen_h = eff_dim(h[DIM_W-1:0], MAX_ROWS);
		n_settings++;
	endtask

	// Mostly writes and queries around the live map, plus some noise over the
	// full coordinate range.
	task automatic fill_random(input int n_items);
		int first, pick;
		first = items_made;
		while (items_made - first < n_items) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				if ($urandom_range(1))
					push_write($urandom_range(63), $urandom_range(63), rand_pixel());
				else
					push_query($urandom_range(63), $urandom_range(63));
			end else if (pick < 45) begin
				push_write(near_coord(gen_w), near_coord(gen_h), rand_pixel());
			end else begin
				push_query(near_coord(gen_w), near_coord(gen_h));
			end
		end
	endtask

	// Driver: holds valid until the item is taken, idles now and then between items.
	always @(posedge clk or negedge arst_n) begin : drive_items
		pixel_op_t op;
		logic      taken;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= ACT_WRITE;
		end else begin
			taken = s_tvalid && s_tready;
			if (taken)
				apply_pixel_op(s_tuser, s_tdata[5:0], s_tdata[11:6], s_tdata[27:12]);
			if (!s_tvalid || taken) begin
				if (pixel_ops.size() != 0 && !(idle_en && $urandom_range(99) < IDLE_PCT)) begin
					op = pixel_ops.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {4'b0, op.pixel, op.row, op.col};
					s_tuser  <= op.action;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result, stalls at random, and runs the long hold on request.
	always @(posedge clk or negedge arst_n) begin : check_results
		rms_result_t got, want;
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left = 0;
			hold_seen = hold_go;
		end else begin
			if (m_tvalid && m_tready) begin
				got = '{rms: m_tdata[15:0], count: m_tdata[19:16], empty: m_tuser};
				if (rms_expected.size() == 0) begin
					report_mismatch("result with none pending", got.rms, -1);
				end else begin
					want = rms_expected.pop_front();
					if (got.empty)
						n_empty++;
					if (got.count == 4'd9)
						n_full++;
					if (got.rms !== want.rms)
						report_mismatch("rms_value", got.rms, want.rms);
					if (got.count !== want.count)
						report_mismatch("neighbor_count", got.count, want.count);
					if (got.empty !== want.empty)
						report_mismatch("empty_flag", got.empty, want.empty);
				end
			end
			if (hold_go != hold_seen) begin
				hold_seen = hold_go;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !(idle_en && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Watchdog: too long with no item moving on either side ends the run.
	int quiet_cycles;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[%0t] watchdog: no item moved for %0d cycles", $realtime, QUIET_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		foreach (model_pix[i])
			model_pix[i] = '0;
		idle_en = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: full-scale corner, zero corner, a full 3x3, at the reset size
		push_write(0, 0, 16'hFFFF);
		push_write(1, 0, 16'hFFFF);
		push_write(0, 1, 16'hFFFF);
		push_write(1, 1, 16'hFFFF);
		push_query(0, 0);
		push_write(63, 63, 16'h0000);
		push_query(63, 63);
		push_query(31, 31);

		// one-cell map: center inside, center just outside, far outside, ignored write
		set_map(1, 1);
		push_query(0, 0);
		push_query(1, 1);
		push_query(5, 5);
		push_write(2, 0, 16'hA5A5);
		push_query(0, 1);

		// empty map: writes dropped, every query empty
		set_map(0, 0);
		push_write(0, 0, 16'h1234);
		push_query(0, 0);

		// random phases: full size with the long receiver hold, oversized with no idling,
		// degenerate and thin maps, then random sizes and a final oversized map
		set_map(64, 64);
		fill_random(225);
		hold_go = ~hold_go;

		set_map(127, 127);
		idle_en = 1'b0;
		fill_random(120);
		wait_quiet();
		idle_en = 1'b1;

		set_map(1, 1);
		fill_random(80);
		set_map(0, 9);
		fill_random(40);
		set_map(9, 0);
		fill_random(40);
		set_map(3, 3);
		fill_random(120);
		set_map(2, 64);
		fill_random(120);
		set_map(64, 2);
		fill_random(120);
		set_map($urandom_range(1, 64), $urandom_range(1, 64));
		fill_random(120);
		set_map($urandom_range(1, 64), $urandom_range(1, 64));
		fill_random(120);
		set_map(100, 70);
		fill_random(120);

		wait_quiet();
		while (rms_expected.size() != 0)
			report_mismatch("result never arrived", -1, rms_expected.pop_front().rms);

		$display("Run covered %0d pixel writes and %0d queries over %0d map sizes.",
		         n_writes, n_queries, n_settings);
		$display("Of the results, %0d had an empty neighborhood and %0d a full 3x3; %0d errors.",
		         n_empty, n_full, err_count);
		if (err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/nrms3_pkg.sv
sv/nrms3_divsqrt.sv
sv/neighborhood_rms_3x3_core.sv
tb/sv/neighborhood_rms_3x3_core_tb.sv
